// File: src/blpf_pkg.sv
// shared constants, types and the microcode table of the biquad low-pass unit
package blpf_pkg;

  localparam int SAMPLE_W_DEF = 24;
  localparam int STATE_W_DEF  = 48;
  localparam int COEF_W       = 26;
  localparam int GAIN_W       = 40;
  localparam int COEF_FRAC    = 22;
  localparam int STATE_FRAC   = 12;
  localparam int Q_FRAC       = COEF_FRAC + STATE_FRAC;
  localparam int ACTION_W     = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 40;
  localparam int GLO_W        = GAIN_W / 2;
  localparam int GHI_W        = GAIN_W - GLO_W;
  localparam int PC_W         = 5;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << COEF_FRAC;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FILTER = 2'd0,
    ACT_PRESET = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0     = 3'd0,
    REG_B1     = 3'd1,
    REG_B2     = 3'd2,
    REG_A1     = 3'd3,
    REG_A2     = 3'd4,
    REG_GAIN   = 3'd5,
    REG_BYPASS = 3'd6
  } cfg_reg_t;

  // multiplier operand selects
  typedef enum logic [2:0] {A_NONE, A_X, A_B0, A_B1, A_B2, A_A1, A_A2} a_sel_t;
  typedef enum logic [3:0] {
    B_NONE, B_D1LO, B_D1HI, B_D2LO, B_D2HI, B_WLO, B_WHI, B_GLO, B_GHI
  } b_sel_t;

  typedef enum logic [1:0] {DST_NONE, DST_W, DST_Y} dst_t;
  typedef enum logic [1:0] {SH_0, SH_STATE, SH_GAIN} sh_t;
  typedef enum logic [1:0] {INIT_NONE, INIT_XQ, INIT_ZERO} init_t;
  typedef enum logic [1:0] {WR_NONE, WR_SHIFT, WR_PRESET, WR_CLEAR} wr_t;
  typedef enum logic [1:0] {EM_NONE, EM_Y, EM_X} emit_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    dst_t   dst;
    logic   neg;
    sh_t    sh;
    init_t  init;
    logic   form_w;
    wr_t    wr;
    emit_t  emit;
    logic   last;
  } ucw_t;

  // accumulate command for the product issued one step earlier
  typedef struct packed {
    dst_t dst;
    logic neg;
    sh_t  sh;
  } pend_t;

  localparam ucw_t UCW_NOP = '{a_sel: A_NONE, b_sel: B_NONE, dst: DST_NONE, neg: 1'b0,
                               sh: SH_0, init: INIT_NONE, form_w: 1'b0, wr: WR_NONE,
                               emit: EM_NONE, last: 1'b0};
  localparam pend_t PEND_NONE = '{dst: DST_NONE, neg: 1'b0, sh: SH_0};

  localparam logic [PC_W-1:0] ENT_FILTER = PC_W'(0);
  localparam logic [PC_W-1:0] ENT_PRESET = PC_W'(12);
  localparam logic [PC_W-1:0] ENT_CLEAR  = PC_W'(16);
  localparam logic [PC_W-1:0] ENT_BYPASS = PC_W'(17);
  localparam logic [PC_W-1:0] UC_LAST    = PC_W'(17);

  // control store
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = UCW_NOP;
    unique case (pc)
      // filter: w = x - a1*d1 - a2*d2, y = b0*w + b1*d1 + b2*d2
      PC_W'(0): begin
        w.a_sel = A_A1; w.b_sel = B_D1LO; w.dst = DST_W; w.neg = 1'b1; w.init = INIT_XQ;
      end
      PC_W'(1): begin
        w.a_sel = A_A1; w.b_sel = B_D1HI; w.dst = DST_W; w.neg = 1'b1; w.sh = SH_STATE;
      end
      PC_W'(2): begin
        w.a_sel = A_A2; w.b_sel = B_D2LO; w.dst = DST_W; w.neg = 1'b1;
      end
      PC_W'(3): begin
        w.a_sel = A_A2; w.b_sel = B_D2HI; w.dst = DST_W; w.neg = 1'b1; w.sh = SH_STATE;
      end
      PC_W'(4): begin
        w.a_sel = A_B1; w.b_sel = B_D1LO; w.dst = DST_Y;
      end
      PC_W'(5): begin
        w.a_sel = A_B1; w.b_sel = B_D1HI; w.dst = DST_Y; w.sh = SH_STATE; w.form_w = 1'b1;
      end
      PC_W'(6): begin
        w.a_sel = A_B2; w.b_sel = B_D2LO; w.dst = DST_Y;
      end
      PC_W'(7): begin
        w.a_sel = A_B2; w.b_sel = B_D2HI; w.dst = DST_Y; w.sh = SH_STATE;
      end
      PC_W'(8): begin
        w.a_sel = A_B0; w.b_sel = B_WLO; w.dst = DST_Y;
      end
      PC_W'(9): begin
        w.a_sel = A_B0; w.b_sel = B_WHI; w.dst = DST_Y; w.sh = SH_STATE;
      end
      PC_W'(10): begin
      end
      PC_W'(11): begin
        w.emit = EM_Y; w.wr = WR_SHIFT; w.last = 1'b1;
      end
      // preset: d1 = d2 = x * gain
      PC_W'(12): begin
        w.a_sel = A_X; w.b_sel = B_GLO; w.dst = DST_W; w.init = INIT_ZERO;
      end
      PC_W'(13): begin
        w.a_sel = A_X; w.b_sel = B_GHI; w.dst = DST_W; w.sh = SH_GAIN;
      end
      PC_W'(14): begin
      end
      PC_W'(15): begin
        w.wr = WR_PRESET; w.last = 1'b1;
      end
      PC_W'(16): begin
        w.wr = WR_CLEAR; w.last = 1'b1;
      end
      PC_W'(17): begin
        w.emit = EM_X; w.last = 1'b1;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  function automatic int max_i(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: src/biquad_lowpass_filter_unit.sv
// biquad low-pass filter unit: microcoded direct form ii datapath with one shared multiplier
//
//   channel  dir  handshake               payload
//   in_      in   in_tvalid / in_tready   in_tuser: action, in_tdata: value
//   out_     out  out_tvalid / out_tready out_tdata: filtered
//   cfg_     in   cfg_wr_en               cfg_addr: register index, cfg_wdata: value
//
// a filtered sample runs 12 microcode steps, set by the ten partial products
// that pass one after another through the single multiplier, a step that lands the last product and y rounding
// a preset takes 4 steps, a clear or a bypassed sample 1 step; the next item is
// taken in the cycle that the last step of the current one completes
// rst_n (synchronous) clears the sequencer, the output valid, both delay elements
// and loads the register reset values
// a step that emits waits while the output register holds an item not yet taken

module biquad_lowpass_filter_unit #(
  parameter int SAMPLE_WIDTH = blpf_pkg::SAMPLE_W_DEF,
  parameter int STATE_WIDTH  = blpf_pkg::STATE_W_DEF,
  localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [TDATA_W-1:0]               in_tdata,   // value
  input  logic [blpf_pkg::ACTION_W-1:0]    in_tuser,   // action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [TDATA_W-1:0]               out_tdata,  // filtered
  input  logic                             cfg_wr_en,
  input  logic [blpf_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [blpf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import blpf_pkg::*;

  // state is split in an unsigned low half and a signed high half
  localparam int LO_W  = STATE_WIDTH / 2;
  localparam int HI_W  = STATE_WIDTH - LO_W;
  localparam int AW    = max_i(COEF_W, SAMPLE_WIDTH);
  localparam int BW    = max_i(max_i(HI_W, LO_W + 1), GHI_W + 1);
  localparam int PW    = AW + BW;
  localparam int ACC_W = max_i(max_i(SAMPLE_WIDTH + Q_FRAC, COEF_W + STATE_WIDTH),
                               SAMPLE_WIDTH + GAIN_W) + 4;

  localparam logic signed [ACC_W-1:0] HALF_W = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] HALF_P = ACC_W'(1) << (COEF_FRAC - STATE_FRAC - 1);
  localparam logic signed [ACC_W-1:0] HALF_Y = ACC_W'(1) << (Q_FRAC - 1);

  function automatic logic [STATE_WIDTH-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-STATE_WIDTH:0] top;
    top = v[ACC_W-1:STATE_WIDTH-1];
    if ((&top) || !(|top)) return v[STATE_WIDTH-1:0];
    return {v[ACC_W-1], {(STATE_WIDTH-1){~v[ACC_W-1]}}};
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-SAMPLE_WIDTH:0] top;
    top = v[ACC_W-1:SAMPLE_WIDTH-1];
    if ((&top) || !(|top)) return v[SAMPLE_WIDTH-1:0];
    return {v[ACC_W-1], {(SAMPLE_WIDTH-1){~v[ACC_W-1]}}};
  endfunction

  // configuration registers
  logic signed [COEF_W-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [GAIN_W-1:0]        gain_r;
  logic                     bypass_r;

  // sequencer
  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  pend_t           pend_r, pend_nxt;
  ucw_t            uw;
  logic            stall, step_go, in_fire, start;
  logic [PC_W-1:0] entry;

  // datapath
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic [STATE_WIDTH-1:0]         d1_r, d2_r, w_r;
  logic signed [AW-1:0]           a_op;
  logic signed [BW-1:0]           b_op;
  logic signed [PW-1:0]           prod_r;
  logic signed [ACC_W-1:0]        accw_r, accw_nxt, accy_r, accy_nxt;
  logic signed [ACC_W-1:0]        prod_ext, addend, acc_src, acc_sum;
  logic signed [ACC_W-1:0]        w_full, pre_full, y_full;
  logic                           out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0]        out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r     <= COEF_ONE;
      b1_r     <= '0;
      b2_r     <= '0;
      a1_r     <= '0;
      a2_r     <= '0;
      gain_r   <= GAIN_ONE;
      bypass_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_B0:     b0_r     <= signed'(cfg_wdata[COEF_W-1:0]);
        REG_B1:     b1_r     <= signed'(cfg_wdata[COEF_W-1:0]);
        REG_B2:     b2_r     <= signed'(cfg_wdata[COEF_W-1:0]);
        REG_A1:     a1_r     <= signed'(cfg_wdata[COEF_W-1:0]);
        REG_A2:     a2_r     <= signed'(cfg_wdata[COEF_W-1:0]);
        REG_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
        REG_BYPASS: bypass_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // dispatch: the action picks the microcode entry, code 3 is dropped
  always_comb begin
    start = 1'b0;
    entry = ENT_FILTER;
    unique case (in_tuser)
      ACT_FILTER: begin
        start = 1'b1;
        entry = bypass_r ? ENT_BYPASS : ENT_FILTER;
      end
      ACT_PRESET: begin
        start = 1'b1;
        entry = ENT_PRESET;
      end
      ACT_CLEAR: begin
        start = 1'b1;
        entry = ENT_CLEAR;
      end
      default: begin
      end
    endcase
  end

  assign uw      = ucode(pc_r);
  assign stall   = (uw.emit != EM_NONE) && out_valid_r && !out_tready;
  assign step_go = busy_r && !stall;
  // a new item may enter in the cycle that the last step retires
  assign in_tready = !busy_r || (step_go && uw.last);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (in_fire && start) begin
      busy_nxt = 1'b1;
      pc_nxt   = entry;
    end else if (step_go) begin
      if (uw.last) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
    pend_nxt = PEND_NONE;
    if (step_go) begin
      pend_nxt = '{dst: uw.dst, neg: uw.neg, sh: uw.sh};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= ENT_FILTER;
      pend_r <= PEND_NONE;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r <= signed'(in_tdata[SAMPLE_WIDTH-1:0]);
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (uw.a_sel)
      A_X:     a_op = AW'(x_r);
      A_B0:    a_op = AW'(b0_r);
      A_B1:    a_op = AW'(b1_r);
      A_B2:    a_op = AW'(b2_r);
      A_A1:    a_op = AW'(a1_r);
      A_A2:    a_op = AW'(a2_r);
      default: a_op = '0;
    endcase
    unique case (uw.b_sel)
      B_D1LO:  b_op = signed'(BW'({1'b0, d1_r[LO_W-1:0]}));
      B_D1HI:  b_op = BW'(signed'(d1_r[STATE_WIDTH-1:LO_W]));
      B_D2LO:  b_op = signed'(BW'({1'b0, d2_r[LO_W-1:0]}));
      B_D2HI:  b_op = BW'(signed'(d2_r[STATE_WIDTH-1:LO_W]));
      B_WLO:   b_op = signed'(BW'({1'b0, w_r[LO_W-1:0]}));
      B_WHI:   b_op = BW'(signed'(w_r[STATE_WIDTH-1:LO_W]));
      B_GLO:   b_op = signed'(BW'({1'b0, gain_r[GLO_W-1:0]}));
      B_GHI:   b_op = signed'(BW'({1'b0, gain_r[GAIN_W-1:GLO_W]}));
      default: b_op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= a_op * b_op;
  end

  // accumulate the registered product, weighted by its half position
  assign prod_ext = ACC_W'(prod_r);
  always_comb begin
    case (pend_r.sh)
      SH_STATE: addend = prod_ext <<< LO_W;
      SH_GAIN:  addend = prod_ext <<< GLO_W;
      default:  addend = prod_ext;
    endcase
    acc_src = (pend_r.dst == DST_Y) ? accy_r : accw_r;
    acc_sum = pend_r.neg ? (acc_src - addend) : (acc_src + addend);
  end

  always_comb begin
    accw_nxt = accw_r;
    accy_nxt = accy_r;
    if (step_go && uw.init == INIT_XQ) begin
      accw_nxt = ACC_W'(x_r) <<< Q_FRAC;
      accy_nxt = '0;
    end else if (step_go && uw.init == INIT_ZERO) begin
      accw_nxt = '0;
    end else if (pend_r.dst == DST_W) begin
      accw_nxt = acc_sum;
    end
    if (pend_r.dst == DST_Y) begin
      accy_nxt = acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    accw_r <= accw_nxt;
    accy_r <= accy_nxt;
  end

  // round half up, then saturate
  assign w_full   = (accw_r + HALF_W) >>> COEF_FRAC;
  assign pre_full = (accw_r + HALF_P) >>> (COEF_FRAC - STATE_FRAC);
  assign y_full   = (accy_r + HALF_Y) >>> Q_FRAC;

  always_ff @(posedge clk) begin
    if (step_go && uw.form_w) begin
      w_r <= sat_state(w_full);
    end
  end

  // delay elements
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (step_go) begin
      case (uw.wr)
        WR_SHIFT: begin
          d2_r <= d1_r;
          d1_r <= w_r;
        end
        WR_PRESET: begin
          d1_r <= sat_state(pre_full);
          d2_r <= sat_state(pre_full);
        end
        WR_CLEAR: begin
          d1_r <= '0;
          d2_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  assign out_valid_nxt = (step_go && uw.emit != EM_NONE) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && uw.emit == EM_Y) begin
      out_data_r <= sat_sample(y_full);
    end else if (step_go && uw.emit == EM_X) begin
      out_data_r <= x_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);

  // a bypassed sample goes straight to its single emit step
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == ACT_FILTER && bypass_r |=> busy_r && pc_r == ENT_BYPASS)
    else $error("bypassed sample did not dispatch to the bypass step");

  // w is rounded only after every feedback product has landed
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && uw.form_w |-> pend_r.dst != DST_W)
    else $error("w formed while a feedback product is still pending");

  // y is taken only after every feed-forward product has landed
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && uw.emit == EM_Y |-> pend_r.dst != DST_Y)
    else $error("y emitted while a feed-forward product is still pending");

  // the step counter never leaves the control store
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= UC_LAST)
    else $error("step counter beyond end of program");

  // a stalled emit step holds its place and the delay line
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && stall |=> busy_r && $stable(pc_r) && $stable(d1_r))
    else $error("sequencer advanced during an output stall");

endmodule
